### rtl/dsmax_pkg.sv
// Shared types and constants for the dynamic sequence max-subarray unit.
// No dependencies; imported by the controller, datapath and top level.
package dsmax_pkg;

	localparam int MAX_LEN    = 1024;
	localparam int VALUE_BITS = 16;

	localparam int KIND_W     = 2;
	localparam int POS_W      = 11;
	localparam int ARG_W      = 16;
	localparam int ANS_W      = 26;
	localparam int STATUS_W   = 2;
	localparam int LENGTH_W   = 11;

	localparam int ADDR_W     = $clog2(MAX_LEN);
	localparam int LEN_W      = $clog2(MAX_LEN + 1);

	typedef enum logic [KIND_W-1:0] {
		K_INSERT  = 2'd0,
		K_DELETE  = 2'd1,
		K_REPLACE = 2'd2,
		K_QUERY   = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;      // capture request fields
		logic setup;      // load scan pointer and stop index
		logic issue;      // read at pointer, advance
		logic write_val;  // write request value at the target index
		logic finish;     // commit length, register result, strobe
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		kind_t   kind;
		status_t err;
		logic    need_scan;
		logic    at_end;
	} stat_t;

endpackage

### rtl/dsmax_ctrl.sv
// Request sequencer for the max-subarray unit: check, scan/shift, write, finish.
// Depends on dsmax_pkg (cmd_t, stat_t, kind_t, status_t).
module dsmax_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  dsmax_pkg::stat_t  stat,
	output dsmax_pkg::cmd_t   cmd,
	output logic              busy
);
	import dsmax_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_DRAIN,
		S_WRITE,
		S_FINISH
	} state_t;

	state_t state_q, state_d;
	logic   busy_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.err != ST_OK) begin
					state_d = S_FINISH;
				end else begin
					unique case (stat.kind)
						K_REPLACE: state_d = S_WRITE;
						K_INSERT:  state_d = stat.need_scan ? S_SCAN : S_WRITE;
						K_DELETE:  state_d = stat.need_scan ? S_SCAN : S_FINISH;
						K_QUERY:   state_d = S_SCAN;
						default:   state_d = S_FINISH;
					endcase
					cmd.setup = stat.need_scan;
				end
			end
			S_SCAN: begin
				cmd.issue = 1'b1;
				if (stat.at_end)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				// last read in flight lands this cycle
				state_d = (stat.kind == K_INSERT) ? S_WRITE : S_FINISH;
			end
			S_WRITE: begin
				cmd.write_val = 1'b1;
				state_d       = S_FINISH;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

### rtl/dsmax_dp.sv
// Datapath: value memory, length, scan pointer, shift writes, running max-sum.
// Depends on dsmax_pkg; driven by dsmax_ctrl through cmd_t/stat_t.
module dsmax_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [dsmax_pkg::KIND_W-1:0]        kind,
	input  logic [dsmax_pkg::POS_W-1:0]         position,
	input  logic signed [dsmax_pkg::ARG_W-1:0]  argument,
	input  dsmax_pkg::cmd_t                     cmd,
	output dsmax_pkg::stat_t                    stat,
	output logic signed [dsmax_pkg::ANS_W-1:0]  answer,
	output logic [dsmax_pkg::STATUS_W-1:0]      status,
	output logic [dsmax_pkg::LENGTH_W-1:0]      length,
	output logic                                done
);
	import dsmax_pkg::*;

	localparam int CMP_W = ((LEN_W > ARG_W) ? LEN_W : ARG_W) + 2;
	localparam int ACC_W = VALUE_BITS + ADDR_W + 1;
	localparam int SAT_W = (ACC_W > ANS_W) ? ACC_W : ANS_W;
	localparam logic signed [SAT_W-1:0] ANS_MAX_X = SAT_W'(2 ** (ANS_W - 1) - 1);
	localparam logic signed [SAT_W-1:0] ANS_MIN_X = SAT_W'(-(2 ** (ANS_W - 1)));

	logic signed [VALUE_BITS-1:0] mem [MAX_LEN];

	kind_t                        kind_q;
	logic [POS_W-1:0]             pos_q;
	logic [ARG_W-1:0]             arg_q;
	logic [LEN_W-1:0]             len_q;
	logic [ADDR_W-1:0]            ptr_q, stop_q, pend_addr_q;
	logic                         pend_q, first_q, done_q;
	logic signed [VALUE_BITS-1:0] rdata_q;
	logic signed [ACC_W-1:0]      run_q, best_q;
	logic signed [ANS_W-1:0]      answer_q;
	logic [STATUS_W-1:0]          status_q;

	logic [CMP_W-1:0]             pos_x, len_x, end_x, at_x;
	status_t                      err;
	logic                         need_scan;
	logic [CMP_W-1:0]             start_x, stop_x;
	logic signed [VALUE_BITS-1:0] new_val;
	logic signed [31:0]           arg_wide;
	logic                         we;
	logic [ADDR_W-1:0]            waddr;
	logic signed [VALUE_BITS-1:0] wdata;
	logic signed [ACC_W-1:0]      v_x, run_d, best_d;
	logic signed [SAT_W-1:0]      best_sat;

	// request decode and range checks
	always_comb begin
		pos_x = CMP_W'(pos_q);
		len_x = CMP_W'(len_q);
		end_x = CMP_W'(arg_q[ARG_W-2:0]);
		at_x  = pos_x - CMP_W'(1);
		err   = ST_OK;
		need_scan = 1'b0;
		start_x   = at_x;
		stop_x    = at_x;
		unique case (kind_q)
			K_INSERT: begin
				if (pos_x == '0 || pos_x > len_x + CMP_W'(1))
					err = ST_RANGE;
				else if (len_x >= CMP_W'(MAX_LEN))
					err = ST_FULL;
				need_scan = (at_x < len_x);
				start_x   = len_x - CMP_W'(1);
				stop_x    = at_x;
			end
			K_DELETE: begin
				if (pos_x == '0 || pos_x > len_x)
					err = ST_RANGE;
				need_scan = (at_x + CMP_W'(1) < len_x);
				start_x   = at_x + CMP_W'(1);
				stop_x    = len_x - CMP_W'(1);
			end
			K_REPLACE: begin
				if (pos_x == '0 || pos_x > len_x)
					err = ST_RANGE;
			end
			K_QUERY: begin
				if (pos_x == '0 || arg_q[ARG_W-1] || end_x < pos_x || end_x > len_x)
					err = ST_RANGE;
				need_scan = 1'b1;
				start_x   = at_x;
				stop_x    = end_x - CMP_W'(1);
			end
			default: err = ST_RANGE;
		endcase
	end

	assign stat.kind      = kind_q;
	assign stat.err       = err;
	assign stat.need_scan = need_scan;
	assign stat.at_end    = (ptr_q == stop_q);

	// sign-extend to 32, then wrap to the stored value width
	assign arg_wide = {{(32 - ARG_W){arg_q[ARG_W-1]}}, arg_q};
	assign new_val  = arg_wide[VALUE_BITS-1:0];

	// memory write port: shifted word from the last read, or the new value
	always_comb begin
		we    = cmd.write_val || (pend_q && (kind_q == K_INSERT || kind_q == K_DELETE));
		wdata = cmd.write_val ? new_val : rdata_q;
		if (cmd.write_val)
			waddr = at_x[ADDR_W-1:0];
		else if (kind_q == K_INSERT)
			waddr = pend_addr_q + ADDR_W'(1);
		else
			waddr = pend_addr_q - ADDR_W'(1);
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.issue)
			rdata_q <= mem[ptr_q];
	end

	// running max-sum over the read stream
	always_comb begin
		v_x = {{(ACC_W - VALUE_BITS){rdata_q[VALUE_BITS-1]}}, rdata_q};
		if (first_q) begin
			run_d  = v_x;
			best_d = v_x;
		end else begin
			run_d  = (run_q > 0) ? run_q + v_x : v_x;
			best_d = (run_d > best_q) ? run_d : best_q;
		end
		best_sat = SAT_W'(best_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q <= kind_t'(kind);
			pos_q  <= position;
			arg_q  <= argument;
		end
		if (cmd.setup) begin
			ptr_q  <= start_x[ADDR_W-1:0];
			stop_q <= stop_x[ADDR_W-1:0];
		end else if (cmd.issue && ptr_q != stop_q) begin
			ptr_q <= (kind_q == K_INSERT) ? ptr_q - ADDR_W'(1) : ptr_q + ADDR_W'(1);
		end
		if (cmd.issue)
			pend_addr_q <= ptr_q;
		if (pend_q && kind_q == K_QUERY) begin
			run_q  <= run_d;
			best_q <= best_d;
		end
		if (cmd.finish) begin
			status_q <= err;
			if (err == ST_OK && kind_q == K_QUERY) begin
				if (best_sat > ANS_MAX_X)
					answer_q <= ANS_MAX_X[ANS_W-1:0];
				else if (best_sat < ANS_MIN_X)
					answer_q <= ANS_MIN_X[ANS_W-1:0];
				else
					answer_q <= best_sat[ANS_W-1:0];
			end else begin
				answer_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			pend_q  <= 1'b0;
			first_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			pend_q <= cmd.issue;
			done_q <= cmd.finish;
			if (cmd.setup)
				first_q <= 1'b1;
			else if (pend_q)
				first_q <= 1'b0;
			if (cmd.finish && err == ST_OK) begin
				if (kind_q == K_INSERT)
					len_q <= len_q + LEN_W'(1);
				else if (kind_q == K_DELETE)
					len_q <= len_q - LEN_W'(1);
			end
		end
	end

	assign answer = answer_q;
	assign status = status_q;
	assign length = LENGTH_W'(len_q);
	assign done   = done_q;

endmodule

### rtl/dynamic_sequence_max_subarray_unit.sv
// Dynamic sequence with range maximum-subarray query, top level.
// Depends on dsmax_pkg, dsmax_ctrl and dsmax_dp.
//
// A request (kind, position, argument) is taken on a clock edge with start high
// and busy low; busy stays high until the request is finished. Exactly one
// result per request appears on answer/status/length for a single cycle with
// done high; the receiver cannot stall, so it must capture the result on that
// edge. A new request may be started in the cycle the result is shown.
// Insert and delete walk the entries from the position to the end of the
// sequence through the value memory, and a query walks its range; replace,
// an append, deleting the last entry and any rejected request need no walk.
// The memory needs no clearing after reset; only entries below the current
// length are ever read.
module dynamic_sequence_max_subarray_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [dsmax_pkg::KIND_W-1:0]        kind,
	input  logic [dsmax_pkg::POS_W-1:0]         position,
	input  logic signed [dsmax_pkg::ARG_W-1:0]  argument,
	output logic                                done,
	output logic signed [dsmax_pkg::ANS_W-1:0]  answer,
	output logic [dsmax_pkg::STATUS_W-1:0]      status,
	output logic [dsmax_pkg::LENGTH_W-1:0]      length
);
	import dsmax_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	dsmax_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	dsmax_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.kind     (kind),
		.position (position),
		.argument (argument),
		.cmd      (cmd),
		.stat     (stat),
		.answer   (answer),
		.status   (status),
		.length   (length),
		.done     (done)
	);

	// a result only closes a transaction that was in progress
	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(busy))
		else $error("result strobe without a request in progress");

	// an accepted request keeps the unit busy on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	// answer is nonzero only for a successful request
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (answer == '0))
		else $error("nonzero answer on a rejected request");

	// length changes only when a result is reported
	assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> (length == $past(length)))
		else $error("length changed without a result");

endmodule

### verif/dsmax_result_checker.sv
// Checker for the dynamic sequence max-subarray unit: watches the request and result ports.
// It keeps its own copy of the sequence and compares every result with the prediction.
// Depends on dsmax_pkg.
`timescale 1ns / 100ps

module dsmax_result_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 busy,
	input  logic [dsmax_pkg::KIND_W-1:0]         kind,
	input  logic [dsmax_pkg::POS_W-1:0]          position,
	input  logic signed [dsmax_pkg::ARG_W-1:0]   argument,
	input  logic                                 done,
	input  logic signed [dsmax_pkg::ANS_W-1:0]   answer,
	input  logic [dsmax_pkg::STATUS_W-1:0]       status,
	input  logic [dsmax_pkg::LENGTH_W-1:0]       length,
	output int                                   outstanding,
	output int                                   mismatch_count,
	output int                                   results_seen,
	output int                                   queries_seen,
	output int                                   rejects_seen
);
	import dsmax_pkg::*;

	localparam longint ANS_HI = (longint'(1) <<< (ANS_W - 1)) - 1;
	localparam longint ANS_LO = -(longint'(1) <<< (ANS_W - 1));

	typedef struct {
		logic signed [ANS_W-1:0] answer;
		status_t                 status;
		logic [LENGTH_W-1:0]     length;
	} result_t;

	logic signed [VALUE_BITS-1:0] seq_vals [MAX_LEN];
	int      seq_len = 0;
	result_t expected_q [$];
	result_t want;
	int      mismatches = 0;
	int      results = 0;
	int      queries = 0;
	int      rejects = 0;

	// Applies one request to the local sequence and returns the result it should give.
	function automatic result_t apply_request(kind_t k, logic [POS_W-1:0] p,
			logic signed [ARG_W-1:0] a);
		result_t r;
		int      at;
		int      last;
		int      i;
		longint  arg_v;
		longint  best;
		longint  run;
		longint  v;
		arg_v    = a;
		at       = int'(p) - 1;
		r.answer = '0;
		r.status = ST_OK;
		case (k)
			K_INSERT: begin
				if (at < 0 || at > seq_len) begin
					r.status = ST_RANGE;
				end else if (seq_len >= MAX_LEN) begin
					r.status = ST_FULL;
				end else begin
					for (i = seq_len; i > at; i--)
						seq_vals[i] = seq_vals[i-1];
					seq_vals[at] = arg_v[VALUE_BITS-1:0];
					seq_len++;
				end
			end
			K_DELETE: begin
				if (at < 0 || at >= seq_len) begin
					r.status = ST_RANGE;
				end else begin
					for (i = at; i < seq_len - 1; i++)
						seq_vals[i] = seq_vals[i+1];
					seq_len--;
				end
			end
			K_REPLACE: begin
				if (at < 0 || at >= seq_len)
					r.status = ST_RANGE;
				else
					seq_vals[at] = arg_v[VALUE_BITS-1:0];
			end
			default: begin
				// end position is signed: a negative end is never a valid range
				last = int'(arg_v - 1);
				if (at < 0 || last < at || last >= seq_len) begin
					r.status = ST_RANGE;
				end else begin
					best = seq_vals[at];
					run  = best;
					for (i = at + 1; i <= last; i++) begin
						v   = seq_vals[i];
						run = (run > 0) ? run + v : v;
						if (run > best)
							best = run;
					end
					if (best > ANS_HI)
						best = ANS_HI;
					if (best < ANS_LO)
						best = ANS_LO;
					r.answer = best[ANS_W-1:0];
				end
			end
		endcase
		r.length = seq_len[LENGTH_W-1:0];
		return r;
	endfunction

	function automatic int field_diff(string name, longint want_v, longint got_v);
		if (want_v == got_v)
			return 0;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q.delete();
			seq_len = 0;
		end else begin
			// retire the shown result first: a new request can be taken on the same edge
			if (done) begin
				results++;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, got answer %0d status %0d length %0d",
						$time, answer, status, length);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					mismatches += field_diff("answer", want.answer, answer);
					mismatches += field_diff("status", want.status, status);
					mismatches += field_diff("length", want.length, length);
				end
			end
			if (start && !busy) begin
				want = apply_request(kind_t'(kind), position, argument);
				expected_q.insert(expected_q.size(), want);
				if (kind_t'(kind) == K_QUERY)
					queries++;
				if (want.status != ST_OK)
					rejects++;
			end
		end
		outstanding    <= expected_q.size();
		mismatch_count <= mismatches;
		results_seen   <= results;
		queries_seen   <= queries;
		rejects_seen   <= rejects;
	end

endmodule

### verif/dynamic_sequence_max_subarray_unit_test.sv
// Testbench top for the dynamic sequence max-subarray unit: clock, reset and request stimulus.
// Depends on dsmax_pkg, dynamic_sequence_max_subarray_unit and dsmax_result_checker.
`timescale 1ns / 100ps

module dynamic_sequence_max_subarray_unit_test;
	import dsmax_pkg::*;

	localparam int CYCLE_LIMIT = 5_000_000;
	localparam int SMALL_ITEMS = 520;

	logic                      clk      = 1'b0;
	logic                      arst_n   = 1'b0;
	logic                      start    = 1'b0;
	logic [KIND_W-1:0]         kind     = '0;
	logic [POS_W-1:0]          position = '0;
	logic signed [ARG_W-1:0]   argument = '0;
	logic                      busy;
	logic                      done;
	logic signed [ANS_W-1:0]   answer;
	logic [STATUS_W-1:0]       status;
	logic [LENGTH_W-1:0]       length;

	int outstanding;
	int mismatch_count;
	int results_seen;
	int queries_seen;
	int rejects_seen;

	int held       = 0;   // sequence length as the stimulus sees it
	int peak_held  = 0;
	int sent       = 0;
	int burst_left = 0;
	int cycles     = 0;
	int caps [6]   = '{1, 2, 4, 8, 16, 40};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	dynamic_sequence_max_subarray_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.kind     (kind),
		.position (position),
		.argument (argument),
		.done     (done),
		.answer   (answer),
		.status   (status),
		.length   (length)
	);

	dsmax_result_checker result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.position       (position),
		.argument       (argument),
		.done           (done),
		.answer         (answer),
		.status         (status),
		.length         (length),
		.outstanding    (outstanding),
		.mismatch_count (mismatch_count),
		.results_seen   (results_seen),
		.queries_seen   (queries_seen),
		.rejects_seen   (rejects_seen)
	);

	initial begin
		while (cycles < CYCLE_LIMIT)
			@(posedge clk) cycles++;
		$display("timeout after %0d cycles", cycles);
		$display("dynamic_sequence_max_subarray_unit_test: errors");
		$finish;
	end

	// idle cycles before the next request, with occasional back-to-back bursts
	function automatic int next_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) begin
			burst_left = $urandom_range(5, 30);
			return 0;
		end
		return $urandom_range(0, 11);
	endfunction

	function automatic logic [ARG_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2, 3, 4: return ARG_W'(int'($urandom_range(0, 16)) - 8);
			5, 6: return ARG_W'(-int'($urandom_range(1, 32768)));
			default: return ARG_W'($urandom);
		endcase
	endfunction

	task automatic send(input kind_t k, input logic [POS_W-1:0] p, input logic [ARG_W-1:0] a);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		kind     <= k;
		position <= p;
		argument <= a;
		do @(posedge clk); while (busy);
		sent++;
		if (k == K_INSERT && p >= 1 && p <= held + 1 && held < MAX_LEN)
			held++;
		else if (k == K_DELETE && p >= 1 && p <= held)
			held--;
		if (held > peak_held)
			peak_held = held;
	endtask

	// one request, mostly well formed, keeping the length near cap
	task automatic random_op(input int cap);
		int                r;
		int                s;
		kind_t             k;
		logic [POS_W-1:0]  p;
		r = $urandom_range(0, 99);
		if (r < 4) begin
			send(kind_t'($urandom_range(0, 3)), POS_W'($urandom), ARG_W'($urandom));
		end else if (r < 10) begin
			// positions at or just outside the edges of the valid window
			case ($urandom_range(0, 2))
				0: p = '0;
				1: p = POS_W'(held + 1);
				default: p = POS_W'(held + 2);
			endcase
			k = kind_t'($urandom_range(0, 3));
			send(k, p, (k == K_QUERY) ? ARG_W'(held + $urandom_range(0, 1)) : rand_value());
		end else if (held == 0 || (r < 40 && held < cap)) begin
			send(K_INSERT, POS_W'($urandom_range(1, held + 1)), rand_value());
		end else if (r < 60 || held > cap) begin
			send(K_DELETE, POS_W'($urandom_range(1, held)), rand_value());
		end else if (r < 72) begin
			send(K_REPLACE, POS_W'($urandom_range(1, held)), rand_value());
		end else begin
			s = $urandom_range(1, held);
			send(K_QUERY, POS_W'(s), ARG_W'($urandom_range(s, held)));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store: every access is rejected
		send(K_QUERY,   11'd1, 16'd1);
		send(K_DELETE,  11'd1, 16'd0);
		send(K_REPLACE, 11'd1, 16'd5);
		send(K_INSERT,  11'd0, 16'd5);
		send(K_INSERT,  11'd2, 16'd5);
		// build -32768, -1, 32767, 0 by front, append and middle inserts
		send(K_INSERT,  11'd1, 16'h7FFF);
		send(K_INSERT,  11'd1, 16'h8000);
		send(K_INSERT,  11'd3, 16'h0000);
		send(K_INSERT,  11'd2, 16'hFFFF);
		send(K_QUERY,   11'd1, 16'd4);
		send(K_QUERY,   11'd1, 16'd2);
		send(K_QUERY,   11'd1, 16'd1);
		send(K_QUERY,   11'd2047, 16'hFFFF);
		send(K_QUERY,   11'd1, 16'h8000);
		send(K_QUERY,   11'd3, 16'd2);
		send(K_QUERY,   11'd1, 16'd5);
		send(K_QUERY,   11'd0, 16'd2);
		send(K_REPLACE, 11'd0, 16'h1234);
		send(K_REPLACE, 11'd5, 16'h1234);
		send(K_REPLACE, 11'd4, 16'h5555);
		send(K_DELETE,  11'd0, 16'd0);
		send(K_DELETE,  11'd5, 16'd0);
		send(K_DELETE,  11'd4, 16'd0);
		send(K_DELETE,  11'd1, 16'd0);
		send(K_QUERY,   11'd1, 16'd2);

		for (int i = 0; i < SMALL_ITEMS; i++)
			random_op(caps[(i / 40) % 6]);

		// let the sequence grow without a cap for the last stretch
		for (int i = 0; i < 30; i++)
			random_op(MAX_LEN);

		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (MAX_LEN + 8) @(posedge clk);

		$display("covered %0d requests (%0d range queries, %0d rejected), %0d results checked,",
			sent, queries_seen, rejects_seen, results_seen);
		$display("sequence lengths from empty up to %0d entries", peak_held);
		if (mismatch_count == 0) begin
			$display("dynamic_sequence_max_subarray_unit_test: clean");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("dynamic_sequence_max_subarray_unit_test: errors");
		end
		$finish;
	end

endmodule
